// File: rtl/sps_pkg.sv
// Shared types, codes and constants for the sorted pair-sum search block.
package sps_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned IDX_W           = 8;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_NO_PAIR  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_STEP,
    S_APP_CMP,
    S_Q_RLO,
    S_Q_RHI,
    S_Q_CMP
  } state_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } out_item_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

// File: rtl/sps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sps_cmp_unit.sv
// Shared 33-bit add and signed compare against a target.
module sps_cmp_unit (
  input  logic signed [sps_pkg::VAL_W-1:0] op_a,
  input  logic signed [sps_pkg::VAL_W-1:0] op_b,
  input  logic signed [sps_pkg::VAL_W-1:0] target,
  output sps_pkg::cmp_res_t                res
);

  logic signed [sps_pkg::VAL_W:0] sum;
  logic signed [sps_pkg::VAL_W:0] tgt;

  always_comb begin
    sum    = {op_a[sps_pkg::VAL_W-1], op_a} + {op_b[sps_pkg::VAL_W-1], op_b};
    tgt    = {target[sps_pkg::VAL_W-1], target};
    res.gt = (sum > tgt);
    res.eq = (sum == tgt);
  end

endmodule

// File: rtl/sorted_pair_sum_search_core.sv
// Sorted value store with in-place insertion and a two-pointer pair-sum search.
// Issue an item by raising start while busy is low; the single result appears on
// out_payload with out_valid high for one cycle and cannot be stalled. Clear, an
// unused request code, an append to a full store and a query of an empty store give
// their result in the cycle after acceptance. An append walks down from the end of the
// store, shifting each stored value greater than the new one up one slot, a read then
// a write per shift, and then writes the new value. A query moves a low and a high
// pointer inward until the pair sum equals the target or the pointers meet; a query
// that finds no pair is the longest case. busy is low again in the result cycle.
// Each search step reads the low and high entries through the store's single read
// port before one pass through the shared add/compare unit.
module sorted_pair_sum_search_core #(
  parameter int unsigned MAX_ENTRIES = sps_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sps_pkg::in_item_t  in_payload,
  output logic               out_valid,
  output sps_pkg::out_item_t out_payload
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned VW = sps_pkg::VAL_W;
  localparam int unsigned IW = sps_pkg::IDX_W;

  sps_pkg::state_e state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [AW-1:0]          lo_r, lo_nxt;
  logic [AW-1:0]          hi_r, hi_nxt;
  logic signed [VW-1:0]   val_r, val_nxt;
  logic signed [VW-1:0]   lo_val_r, lo_val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sps_pkg::out_item_t     out_r, out_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VW-1:0]          ram_rdata;

  logic signed [VW-1:0]   alu_a;
  logic signed [VW-1:0]   alu_b;
  sps_pkg::cmp_res_t      alu_res;

  logic [CW-1:0]          pos_m1;
  logic [CW-1:0]          count_m1;
  logic [AW+IW-1:0]       lo_ext;
  logic [AW+IW-1:0]       hi_ext;

  sps_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sps_cmp_unit u_cmp (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .target (val_r),
    .res    (alu_res)
  );

  assign pos_m1   = pos_r - CW'(1);
  assign count_m1 = count_r - CW'(1);
  assign lo_ext   = {{IW{1'b0}}, lo_r};
  assign hi_ext   = {{IW{1'b0}}, hi_r};

  // append compares stored value against the new one alone; query adds both ends
  always_comb begin
    if (state_r == sps_pkg::S_Q_CMP) begin
      alu_a = lo_val_r;
      alu_b = ram_rdata;
    end else begin
      alu_a = ram_rdata;
      alu_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sps_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    val_r    <= val_nxt;
    lo_val_r <= lo_val_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    val_nxt       = val_r;
    lo_val_nxt    = lo_val_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[AW-1:0];
    ram_wdata     = val_r;
    ram_raddr     = lo_r;

    case (state_r)
      sps_pkg::S_IDLE: begin
        if (start) begin
          val_nxt               = in_payload.operand_value;
          out_nxt.status        = sps_pkg::ST_ACCEPTED;
          out_nxt.first_index   = '0;
          out_nxt.second_index  = '0;
          case (in_payload.req_type)
            sps_pkg::REQ_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            sps_pkg::REQ_APPEND: begin
              if (count_r == CW'(MAX_ENTRIES)) begin
                out_nxt.status = sps_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                pos_nxt   = count_r;
                state_nxt = sps_pkg::S_APP_STEP;
              end
            end
            sps_pkg::REQ_QUERY: begin
              if (count_r == '0) begin
                out_nxt.status = sps_pkg::ST_NO_PAIR;
                out_valid_nxt  = 1'b1;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = count_m1[AW-1:0];
                state_nxt = sps_pkg::S_Q_RLO;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      sps_pkg::S_APP_STEP: begin
        if (pos_r == '0) begin
          ram_we        = 1'b1;
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = sps_pkg::S_IDLE;
        end else begin
          ram_raddr = pos_m1[AW-1:0];
          state_nxt = sps_pkg::S_APP_CMP;
        end
      end

      sps_pkg::S_APP_CMP: begin
        ram_we = 1'b1;
        if (alu_res.gt) begin
          // shift the larger neighbor up one slot
          ram_wdata = ram_rdata;
          pos_nxt   = pos_m1;
          state_nxt = sps_pkg::S_APP_STEP;
        end else begin
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = sps_pkg::S_IDLE;
        end
      end

      sps_pkg::S_Q_RLO: begin
        if (lo_r == hi_r) begin
          out_nxt.status = sps_pkg::ST_NO_PAIR;
          out_valid_nxt  = 1'b1;
          state_nxt      = sps_pkg::S_IDLE;
        end else begin
          ram_raddr = lo_r;
          state_nxt = sps_pkg::S_Q_RHI;
        end
      end

      sps_pkg::S_Q_RHI: begin
        lo_val_nxt = ram_rdata;
        ram_raddr  = hi_r;
        state_nxt  = sps_pkg::S_Q_CMP;
      end

      sps_pkg::S_Q_CMP: begin
        if (alu_res.eq) begin
          out_nxt.status       = sps_pkg::ST_FOUND;
          out_nxt.first_index  = lo_ext[IW-1:0];
          out_nxt.second_index = hi_ext[IW-1:0];
          out_valid_nxt        = 1'b1;
          state_nxt            = sps_pkg::S_IDLE;
        end else begin
          if (alu_res.gt) begin
            hi_nxt = hi_r - AW'(1);
          end else begin
            lo_nxt = lo_r + AW'(1);
          end
          state_nxt = sps_pkg::S_Q_RLO;
        end
      end

      default: begin
        state_nxt = sps_pkg::S_IDLE;
      end
    endcase
  end

  assign busy        = (state_r != sps_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

// File: rtl/sps_checker.sv
// Port-level checks for the sorted pair-sum search core, bound into the core module.
module sps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input sps_pkg::in_item_t  in_payload,
  input logic               out_valid,
  input sps_pkg::out_item_t out_payload
);

  // reset leaves no result pending and the block idle
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("result or busy right after reset");

  // a result only follows an accepted item or ongoing work
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a preceding item");

  // work begins only from an accepted item
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted item");

  // indices are zero unless a pair was found
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_payload.status != sps_pkg::ST_FOUND))
      |-> ((out_payload.first_index == '0) && (out_payload.second_index == '0)))
    else $error("nonzero index without a found pair");

  // a pending result ends the item, so busy drops with it
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy held across its own result");

endmodule

bind sorted_pair_sum_search_core sps_checker u_sps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_payload (out_payload)
);

// File: sim/tb_top.sv
// Self-checking testbench for the sorted pair-sum search core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = sps_pkg::MAX_ENTRIES_DEF;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic signed [sps_pkg::VAL_W-1:0] VAL_MIN =
    {1'b1, {(sps_pkg::VAL_W-1){1'b0}}};
  localparam logic signed [sps_pkg::VAL_W-1:0] VAL_MAX =
    {1'b0, {(sps_pkg::VAL_W-1){1'b1}}};
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 3 * STORE_DEPTH + 16;

  // Mirrors the sorted store and predicts the status/indices of every item.
  class pair_sum_scoreboard;
    logic signed [sps_pkg::VAL_W-1:0] store_vals [STORE_DEPTH];
    int unsigned                      fill;
    sps_pkg::out_item_t               pending[$];
    int unsigned                      errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_item(sps_pkg::in_item_t it);
      sps_pkg::out_item_t             exp;
      int unsigned                    pos;
      int unsigned                    lo;
      int unsigned                    hi;
      logic signed [sps_pkg::VAL_W:0] pair_sum;
      logic signed [sps_pkg::VAL_W:0] goal;
      exp = '0;
      exp.status = sps_pkg::ST_ACCEPTED;
      case (it.req_type)
        sps_pkg::REQ_CLEAR: fill = 0;
        sps_pkg::REQ_APPEND: begin
          if (fill >= STORE_DEPTH) begin
            exp.status = sps_pkg::ST_FULL;
          end else begin
            // equal values stay ahead of the new one
            pos = fill;
            while (pos > 0 && store_vals[pos-1] > it.operand_value) begin
              store_vals[pos] = store_vals[pos-1];
              pos--;
            end
            store_vals[pos] = it.operand_value;
            fill++;
          end
        end
        sps_pkg::REQ_QUERY: begin
          exp.status = sps_pkg::ST_NO_PAIR;
          if (fill > 0) begin
            goal = $signed({it.operand_value[sps_pkg::VAL_W-1], it.operand_value});
            lo = 0;
            hi = fill - 1;
            while (lo != hi) begin
              pair_sum = $signed({store_vals[lo][sps_pkg::VAL_W-1], store_vals[lo]})
                       + $signed({store_vals[hi][sps_pkg::VAL_W-1], store_vals[hi]});
              if (pair_sum == goal) begin
                exp.status       = sps_pkg::ST_FOUND;
                exp.first_index  = lo[sps_pkg::IDX_W-1:0];
                exp.second_index = hi[sps_pkg::IDX_W-1:0];
                break;
              end else if (pair_sum > goal) begin
                hi--;
              end else begin
                lo++;
              end
            end
          end
        end
        default: ;
      endcase
      pending.push_back(exp);
    endfunction

    function void check_result(sps_pkg::out_item_t got);
      sps_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: got status %0d idx %0d/%0d", $time,
                 got.status, got.first_index, got.second_index);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                 exp.status, got.status);
        errors++;
      end
      if (got.first_index !== exp.first_index) begin
        $display("%0t: first_index mismatch: expected %0d, actual %0d", $time,
                 exp.first_index, got.first_index);
        errors++;
      end
      if (got.second_index !== exp.second_index) begin
        $display("%0t: second_index mismatch: expected %0d, actual %0d", $time,
                 exp.second_index, got.second_index);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  sps_pkg::in_item_t  in_payload;
  logic               out_valid;
  sps_pkg::out_item_t out_payload;

  pair_sum_scoreboard sb;
  bit                 calm;
  int unsigned        items_sent;
  logic signed [sps_pkg::VAL_W-1:0] loaded[$];

  sorted_pair_sum_search_core #(
    .MAX_ENTRIES(STORE_DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_payload(out_payload)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_payload);
    end
  end

  function automatic sps_pkg::in_item_t make_item(logic [1:0] kind,
                                                  logic signed [sps_pkg::VAL_W-1:0] v);
    sps_pkg::in_item_t it;
    it.req_type      = kind;
    it.operand_value = v;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [sps_pkg::VAL_W-1:0] pick_value(int unsigned flavor);
    case (flavor)
      0: return $urandom;
      1: return int'($urandom_range(16)) - 8;
      default: begin
        case ($urandom_range(5))
          0: return VAL_MIN;
          1: return VAL_MIN + 1;
          2: return VAL_MAX;
          3: return VAL_MAX - 1;
          4: return -1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // Holds the item until the core takes it; junk rides the bus during gaps.
  task automatic drive_item(sps_pkg::in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      in_payload.operand_value = $urandom;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    in_payload = it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (it.req_type != REQ_UNUSED) items_sent++;
    if (it.req_type == sps_pkg::REQ_CLEAR) loaded.delete();
    if (it.req_type == sps_pkg::REQ_APPEND) loaded.push_back(it.operand_value);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Usually a clear, then a load, then a burst of queries aimed mostly at real pair sums.
  task automatic run_sequence(int unsigned n_load);
    int unsigned flavor;
    int unsigned n_query;
    int unsigned a;
    int unsigned b;
    logic signed [sps_pkg::VAL_W-1:0] goal;
    flavor = $urandom_range(2);
    if ($urandom_range(4) != 0) drive_item(make_item(sps_pkg::REQ_CLEAR, $urandom));
    repeat (n_load) drive_item(make_item(sps_pkg::REQ_APPEND, pick_value(flavor)));
    n_query = $urandom_range(1, 6);
    repeat (n_query) begin
      case ($urandom_range(9))
        0, 1: goal = $urandom;
        2, 3: goal = pick_value(1);
        default: begin
          if (loaded.size() >= 2) begin
            a = $urandom_range(loaded.size() - 1);
            b = $urandom_range(loaded.size() - 1);
            if (a == b) b = (a + 1) % loaded.size();
            goal = loaded[a] + loaded[b];
          end else begin
            goal = pick_value(flavor);
          end
        end
      endcase
      drive_item(make_item(sps_pkg::REQ_QUERY, goal));
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 5)) begin
      drive_item(make_item(2'($urandom_range(3)), pick_value($urandom_range(2))));
    end
  endtask

  initial begin
    int unsigned seq_no;
    int unsigned r;
    int unsigned n_load;
    sb         = new();
    calm       = 1'b0;
    items_sent = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_payload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    drive_item(make_item(sps_pkg::REQ_QUERY, 0));            // empty store
    drive_item(make_item(REQ_UNUSED, VAL_MAX));
    drive_item(make_item(sps_pkg::REQ_APPEND, VAL_MAX));
    drive_item(make_item(sps_pkg::REQ_QUERY, -2));           // single entry
    drive_item(make_item(sps_pkg::REQ_APPEND, VAL_MIN));
    drive_item(make_item(sps_pkg::REQ_APPEND, 0));
    drive_item(make_item(sps_pkg::REQ_APPEND, VAL_MAX));     // duplicate goes after
    drive_item(make_item(sps_pkg::REQ_QUERY, -1));
    drive_item(make_item(sps_pkg::REQ_QUERY, 0));
    drive_item(make_item(sps_pkg::REQ_QUERY, VAL_MIN));
    drive_item(make_item(sps_pkg::REQ_QUERY, VAL_MAX));
    drive_item(make_item(sps_pkg::REQ_APPEND, VAL_MIN));
    drive_item(make_item(sps_pkg::REQ_QUERY, VAL_MIN));
    drive_item(make_item(sps_pkg::REQ_CLEAR, VAL_MIN));
    drive_item(make_item(sps_pkg::REQ_QUERY, 5));
    drive_item(make_item(sps_pkg::REQ_APPEND, 3));
    drive_item(make_item(sps_pkg::REQ_APPEND, 3));
    drive_item(make_item(sps_pkg::REQ_QUERY, 6));
    drive_item(make_item(REQ_UNUSED, -1));
    drive_item(make_item(sps_pkg::REQ_QUERY, 6));            // unused code left state alone
    drive_item(make_item(sps_pkg::REQ_CLEAR, -1));
    drive_item(make_item(sps_pkg::REQ_QUERY, 6));

    wait_drained();
    items_sent = 0;
    seq_no     = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(5) == 0);
      if (seq_no == 0 || $urandom_range(7) == 0) wait_drained();
      r = $urandom_range(99);
      // first sequence overfills the store
      if (seq_no == 0 || r < 3) begin
        n_load = $urandom_range(STORE_DEPTH - 6, STORE_DEPTH + 6);
        if (seq_no == 0) n_load = STORE_DEPTH + 2;
        run_sequence(n_load);
      end else if (r < 85) begin
        n_load = (r < 70) ? $urandom_range(12) : $urandom_range(13, 40);
        run_sequence(n_load);
      end else begin
        run_noise();
      end
      seq_no++;
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
